[rtl/kwg_pkg.sv]
package kwg_pkg;

  localparam int RAW_W    = 10;
  localparam int BRIGHT_W = 8;
  localparam int TIME_W   = 32;
  localparam int MS_W     = 16;
  localparam int CMD_W    = 3;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Divider sizing: the numerator magnitude is at most 1023 * 255, which fits in 18 bits.
  localparam int NUM_W     = 18;
  localparam int DEN_W     = RAW_W;
  localparam int DIV_STEPS = NUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [BRIGHT_W-1:0] LEVEL_RESET  = 8'd150;
  localparam logic [BRIGHT_W-1:0] SETUP_BRIGHT = 8'd200;
  localparam logic [BRIGHT_W-1:0] PHASE_MAX    = 8'd255;
  localparam logic [BRIGHT_W-1:0] PHASE_NEXT   = 8'd3;
  localparam logic [BRIGHT_W-1:0] PHASE_SETUP  = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POT_MIN    = 3'd0,
    CFG_POT_MAX    = 3'd1,
    CFG_INVERT     = 3'd2,
    CFG_BRIGHT_MIN = 3'd3,
    CFG_BRIGHT_MAX = 3'd4,
    CFG_MIN_SWING  = 3'd5,
    CFG_WINDOW     = 3'd6,
    CFG_PAUSE      = 3'd7
  } cfg_idx_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE        = 3'd0,
    CMD_NEXT        = 3'd1,
    CMD_PREV        = 3'd2,
    CMD_ENTER_SETUP = 3'd3,
    CMD_LEAVE_SETUP = 3'd4
  } cmd_code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_MAPB,
    ST_TRACK
  } ctrl_state_t;

  typedef struct packed {
    logic [RAW_W-1:0]    pot_min;
    logic [RAW_W-1:0]    pot_max;
    logic                invert;
    logic [BRIGHT_W-1:0] bright_min;
    logic [BRIGHT_W-1:0] bright_max;
    logic [BRIGHT_W-1:0] min_swing;
    logic [MS_W-1:0]     window_ms;
    logic [MS_W-1:0]     pause_ms;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic map_b;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic slot_free;
  } ctrl_status_t;

endpackage

[rtl/kwg_in_if.sv]
interface kwg_in_if;
  logic                         valid;
  logic                         ready;
  logic [kwg_pkg::RAW_W-1:0]    sample;
  logic [kwg_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

[rtl/kwg_out_if.sv]
interface kwg_out_if;
  logic                          valid;
  logic                          ready;
  logic [kwg_pkg::BRIGHT_W-1:0]  brightness;
  logic [kwg_pkg::BRIGHT_W-1:0]  shown_brightness;
  logic [kwg_pkg::CMD_W-1:0]     command;
  logic                          setup_active;

  modport source (output valid, output brightness, output shown_brightness,
                  output command, output setup_active, input ready);
  modport sink   (input valid, input brightness, input shown_brightness,
                  input command, input setup_active, output ready);
endinterface

[rtl/kwg_cfg_regs.sv]
module kwg_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kwg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kwg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output kwg_pkg::cfg_t                     cfg
);

  kwg_pkg::cfg_t cfg_r;
  kwg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (kwg_pkg::cfg_idx_t'(cfg_index))
        kwg_pkg::CFG_POT_MIN:    cfg_nxt.pot_min    = cfg_wdata[kwg_pkg::RAW_W-1:0];
        kwg_pkg::CFG_POT_MAX:    cfg_nxt.pot_max    = cfg_wdata[kwg_pkg::RAW_W-1:0];
        kwg_pkg::CFG_INVERT:     cfg_nxt.invert     = cfg_wdata[0];
        kwg_pkg::CFG_BRIGHT_MIN: cfg_nxt.bright_min = cfg_wdata[kwg_pkg::BRIGHT_W-1:0];
        kwg_pkg::CFG_BRIGHT_MAX: cfg_nxt.bright_max = cfg_wdata[kwg_pkg::BRIGHT_W-1:0];
        kwg_pkg::CFG_MIN_SWING:  cfg_nxt.min_swing  = cfg_wdata[kwg_pkg::BRIGHT_W-1:0];
        kwg_pkg::CFG_WINDOW:     cfg_nxt.window_ms  = cfg_wdata;
        kwg_pkg::CFG_PAUSE:      cfg_nxt.pause_ms   = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pot_min    <= 10'd0;
      cfg_r.pot_max    <= 10'd1023;
      cfg_r.invert     <= 1'b0;
      cfg_r.bright_min <= 8'd0;
      cfg_r.bright_max <= 8'd255;
      cfg_r.min_swing  <= 8'd20;
      cfg_r.window_ms  <= 16'd3000;
      cfg_r.pause_ms   <= 16'd400;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/kwg_ctrl.sv]
module kwg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  kwg_pkg::ctrl_status_t  status,
  output kwg_pkg::ctrl_cmd_t     cmd
);

  kwg_pkg::ctrl_state_t state_r;
  kwg_pkg::ctrl_state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kwg_pkg::ST_IDLE:  if (in_valid) begin
        state_nxt = kwg_pkg::ST_MUL;
      end
      kwg_pkg::ST_MUL:   state_nxt = kwg_pkg::ST_DIV;
      kwg_pkg::ST_DIV:   if (status.div_last) begin
        state_nxt = kwg_pkg::ST_MAPB;
      end
      kwg_pkg::ST_MAPB:  state_nxt = kwg_pkg::ST_TRACK;
      kwg_pkg::ST_TRACK: if (status.slot_free) begin
        state_nxt = kwg_pkg::ST_IDLE;
      end
      default:           state_nxt = kwg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      kwg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      kwg_pkg::ST_MUL:   cmd.mul      = 1'b1;
      kwg_pkg::ST_DIV:   cmd.div_step = 1'b1;
      kwg_pkg::ST_MAPB:  cmd.map_b    = 1'b1;
      kwg_pkg::ST_TRACK: cmd.commit   = status.slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kwg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  // The divider always runs to its last step before the brightness is finished.
  a_mapb_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.map_b |-> $past(cmd.div_step) && $past(status.div_last))
    else $error("brightness finished without a completed division");

  // A new request is never taken while an earlier one is still being worked on.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready && cmd.mul)
    else $error("request accepted during an active computation");

  // Each request is committed at most once: after a commit the sequencer is idle.
  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_ready && !cmd.commit)
    else $error("result committed twice");
`endif

endmodule

[rtl/kwg_datapath.sv]
module kwg_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kwg_pkg::cfg_t                    cfg,
  input  logic [kwg_pkg::RAW_W-1:0]        in_sample,
  input  logic [kwg_pkg::TIME_W-1:0]       in_now_ms,
  input  kwg_pkg::ctrl_cmd_t               cmd,
  output kwg_pkg::ctrl_status_t            status,
  kwg_out_if.source                        out_ch
);

  localparam int BW = kwg_pkg::BRIGHT_W;
  localparam int TW = kwg_pkg::TIME_W;

  // Operand capture.
  logic [kwg_pkg::RAW_W-1:0]   v_clamp;
  logic [kwg_pkg::RAW_W:0]     v_mirror;
  logic [kwg_pkg::RAW_W-1:0]   v_sel;
  logic signed [kwg_pkg::RAW_W:0] voff_r, den_r;
  logic signed [BW:0]          bdiff_r;
  logic [TW-1:0]               now_r;

  // Multiply and divider operands.
  logic signed [kwg_pkg::RAW_W+BW+1:0] prod;
  logic [kwg_pkg::RAW_W+BW+1:0]        prod_mag;
  logic [kwg_pkg::RAW_W:0]             den_abs;
  logic                                q_neg_r, den_zero_r;
  logic [kwg_pkg::DEN_W-1:0]           den_mag_r;
  logic [kwg_pkg::NUM_W-1:0]           nq_r;
  logic [kwg_pkg::DEN_W-1:0]           rem_r;
  logic [kwg_pkg::DIV_CNT_W-1:0]       cnt_r;
  logic [kwg_pkg::DEN_W:0]             rem_sh;
  logic                                rem_ge;
  logic [kwg_pkg::DEN_W:0]             rem_sub;

  logic [BW-1:0] q8, q_signed, b_nxt, b_r;

  // Tracker state.
  logic [BW-1:0] level_r, level_nxt;
  logic          active_r, active_nxt;
  logic [TW-1:0] start_time_r, start_time_nxt;
  logic [TW-1:0] last_time_r, last_time_nxt;
  logic          first_up_r, first_up_nxt;
  logic [BW-1:0] start_level_r, start_level_nxt;
  logic [BW-1:0] phase_r, phase_nxt;
  logic          setup_r, setup_nxt;
  kwg_pkg::cmd_code_t code_nxt;

  logic              changed, up, reversal, swing_short, expired;
  logic signed [BW+1:0] swing;
  logic [TW-1:0]     since_start, since_change;

  // Result register.
  logic          out_valid_r;
  logic [BW-1:0] out_bright_r, out_shown_r;
  logic [kwg_pkg::CMD_W-1:0] out_cmd_r;
  logic          out_setup_r;

  // Clamp, optional mirror, and the signed offsets of the linear map.
  always_comb begin
    if (in_sample < cfg.pot_min) begin
      v_clamp = cfg.pot_min;
    end else if (in_sample > cfg.pot_max) begin
      v_clamp = cfg.pot_max;
    end else begin
      v_clamp = in_sample;
    end
    v_mirror = {1'b0, cfg.pot_max} + {1'b0, cfg.pot_min} - {1'b0, v_clamp};
    v_sel    = cfg.invert ? v_mirror[kwg_pkg::RAW_W-1:0] : v_clamp;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      voff_r  <= $signed({1'b0, v_sel}) - $signed({1'b0, cfg.pot_min});
      den_r   <= $signed({1'b0, cfg.pot_max}) - $signed({1'b0, cfg.pot_min});
      bdiff_r <= $signed({1'b0, cfg.bright_max}) - $signed({1'b0, cfg.bright_min});
      now_r   <= in_now_ms;
    end
  end

  // Sign-magnitude split so the divider works on unsigned values and truncates toward zero.
  always_comb begin
    prod     = voff_r * bdiff_r;
    prod_mag = prod[$bits(prod)-1] ? -prod : prod;
    den_abs  = den_r[kwg_pkg::RAW_W] ? -den_r : den_r;
  end

  // Restoring divider, one quotient bit per cycle.
  always_comb begin
    rem_sh  = {rem_r, nq_r[kwg_pkg::NUM_W-1]};
    rem_ge  = rem_sh >= {1'b0, den_mag_r};
    rem_sub = rem_sh - {1'b0, den_mag_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      q_neg_r    <= prod[$bits(prod)-1] ^ den_r[kwg_pkg::RAW_W];
      den_zero_r <= (den_r == '0);
      den_mag_r  <= den_abs[kwg_pkg::DEN_W-1:0];
      nq_r       <= prod_mag[kwg_pkg::NUM_W-1:0];
      rem_r      <= '0;
    end else if (cmd.div_step) begin
      nq_r  <= {nq_r[kwg_pkg::NUM_W-2:0], rem_ge};
      rem_r <= rem_ge ? rem_sub[kwg_pkg::DEN_W-1:0] : rem_sh[kwg_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.mul) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // The sequencer may commit when the result register is empty or is being emptied.
  assign status = '{div_last:  (cnt_r == kwg_pkg::DIV_CNT_W'(kwg_pkg::DIV_STEPS - 1)),
                    slot_free: (!out_valid_r || out_ch.ready)};

  // Only the low byte of the mapped value is kept, so only the low quotient byte matters.
  always_comb begin
    q8       = nq_r[BW-1:0];
    q_signed = q_neg_r ? -q8 : q8;
    b_nxt    = den_zero_r ? cfg.bright_min : q_signed + cfg.bright_min;
  end

  always_ff @(posedge clk) begin
    if (cmd.map_b) begin
      b_r <= b_nxt;
    end
  end

  // Gesture tracker update.
  always_comb begin
    changed      = (b_r != level_r);
    up           = first_up_r ^ ~phase_r[0];
    reversal     = up ? (level_r > b_r) : (level_r < b_r);
    swing        = up ? ($signed({2'b00, level_r}) - $signed({2'b00, start_level_r}))
                      : ($signed({2'b00, start_level_r}) - $signed({2'b00, level_r}));
    swing_short  = swing < $signed({2'b00, cfg.min_swing});
    since_start  = now_r - start_time_r;
    since_change = now_r - last_time_r;
    expired      = (since_start > {{(TW-kwg_pkg::MS_W){1'b0}}, cfg.window_ms}) ||
                   (since_change > {{(TW-kwg_pkg::MS_W){1'b0}}, cfg.pause_ms});

    level_nxt       = level_r;
    active_nxt      = active_r;
    start_time_nxt  = start_time_r;
    last_time_nxt   = last_time_r;
    first_up_nxt    = first_up_r;
    start_level_nxt = start_level_r;
    phase_nxt       = phase_r;
    setup_nxt       = setup_r;
    code_nxt        = kwg_pkg::CMD_NONE;

    if (changed) begin
      level_nxt     = b_r;
      last_time_nxt = now_r;
      if (!active_r) begin
        active_nxt      = 1'b1;
        start_time_nxt  = now_r;
        first_up_nxt    = b_r > level_r;
        start_level_nxt = level_r;
        phase_nxt       = 8'd1;
      end else if (reversal) begin
        if (phase_r[0] && swing_short) begin
          active_nxt = 1'b0;
        end else if (phase_r != kwg_pkg::PHASE_MAX) begin
          phase_nxt = phase_r + 1'b1;
        end
      end
    end else if (active_r && expired) begin
      active_nxt = 1'b0;
      if (phase_r == kwg_pkg::PHASE_NEXT && !setup_r) begin
        code_nxt = first_up_r ? kwg_pkg::CMD_NEXT : kwg_pkg::CMD_PREV;
      end else if (phase_r == kwg_pkg::PHASE_SETUP) begin
        code_nxt  = setup_r ? kwg_pkg::CMD_LEAVE_SETUP : kwg_pkg::CMD_ENTER_SETUP;
        setup_nxt = !setup_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r       <= kwg_pkg::LEVEL_RESET;
      active_r      <= 1'b0;
      start_time_r  <= '0;
      last_time_r   <= '0;
      first_up_r    <= 1'b1;
      start_level_r <= '0;
      phase_r       <= '0;
      setup_r       <= 1'b0;
    end else if (cmd.commit) begin
      level_r       <= level_nxt;
      active_r      <= active_nxt;
      start_time_r  <= start_time_nxt;
      last_time_r   <= last_time_nxt;
      first_up_r    <= first_up_nxt;
      start_level_r <= start_level_nxt;
      phase_r       <= phase_nxt;
      setup_r       <= setup_nxt;
    end
  end

  // Output register: holds one finished result while the next request is computed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_bright_r <= b_r;
      out_shown_r  <= setup_nxt ? kwg_pkg::SETUP_BRIGHT : b_r;
      out_cmd_r    <= code_nxt;
      out_setup_r  <= setup_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.brightness       = out_bright_r;
  assign out_ch.shown_brightness = out_shown_r;
  assign out_ch.command          = out_cmd_r;
  assign out_ch.setup_active     = out_setup_r;

`ifndef SYNTHESIS
  // A running gesture always has at least one counted phase.
  a_active_phase: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> phase_r != '0)
    else $error("active gesture with zero phases");

  // The shown brightness departs from the mapped one only in setup.
  a_shown_setup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_shown_r != out_bright_r) |-> out_setup_r)
    else $error("shown brightness overridden outside setup");

  // Entering setup is reported together with setup active, leaving without it.
  a_setup_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_cmd_r == kwg_pkg::CMD_ENTER_SETUP ||
                    out_cmd_r == kwg_pkg::CMD_LEAVE_SETUP)
      |-> out_setup_r == (out_cmd_r == kwg_pkg::CMD_ENTER_SETUP))
    else $error("setup command disagrees with setup flag");
`endif

endmodule

[rtl/knob_wiggle_gesture_detector.sv]
// Knob wiggle gesture detector. Each request carries an averaged 10-bit knob
// reading and a millisecond timestamp; each request yields exactly one result
// with the mapped brightness, the brightness to show (200 while in setup), a
// command code and the setup flag. At the edge that accepts a request the
// reading is clamped and the operands are captured; then the product is
// formed, the bit-serial restoring divider of the linear map runs to its
// last step, the brightness is finished and the gesture tracker is updated.
// A new request is accepted only after the previous one has passed the
// tracker update. A finished result sits in an output register, so the next
// request is accepted and worked on while the previous result waits to be
// taken; the tracker update stalls only if that register is still full.
// Configuration registers are written through the cfg_ port and must only be
// written while no request is in flight.
module knob_wiggle_gesture_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  kwg_in_if.sink                            in_ch,
  kwg_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [kwg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kwg_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  kwg_pkg::cfg_t         cfg;
  kwg_pkg::ctrl_cmd_t    cmd;
  kwg_pkg::ctrl_status_t status;

  // Register file holding the eight settings of the map and the tracker.
  kwg_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Sequencer: accepts a request, walks it through multiply, divide and update.
  kwg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: linear map, divider, gesture tracker and the result register.
  kwg_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_sample (in_ch.sample),
    .in_now_ms (in_ch.now_ms),
    .cmd       (cmd),
    .status    (status),
    .out_ch    (out_ch)
  );

endmodule

[test/knob_wiggle_gesture_detector_test.sv]
module knob_wiggle_gesture_detector_test;

  // Knob requests (sample plus millisecond stamp) go in over the request
  // channel, and one readout per request comes back on the result channel.
  // A model of the mapping and of the gesture tracker runs alongside the
  // block. Every accepted request is run through that model, and the readout
  // it predicts is queued. Every readout the block hands over is compared
  // field by field with the oldest queued one.
  //
  // The run has two parts. A short table of directed requests runs under the
  // reset settings. It covers both knob extremes, a three-phase gesture that
  // gives "previous", entering and leaving setup, a three-phase gesture inside
  // setup, a gesture cancelled by a small swing, and a pause that spans the
  // 32-bit wrap of the millisecond counter. After that come phases of random
  // requests. Each phase uses its own register settings, and the first phases
  // pin the extreme settings. Most random requests are well-formed wiggles
  // with random content. The rest are timid wiggles, slow wiggles and plain
  // noise.

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [kwg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kwg_pkg::CFG_DATA_W-1:0] cfg_wdata;

  kwg_in_if knob_if ();
  kwg_out_if readout_if ();

  knob_wiggle_gesture_detector uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (knob_if),
    .out_ch   (readout_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // One readout as the block reports it.
  typedef struct packed {
    logic [kwg_pkg::BRIGHT_W-1:0] brightness;
    logic [kwg_pkg::BRIGHT_W-1:0] shown;
    kwg_pkg::cmd_code_t           command;
    logic                         setup;
  } readout_t;

  // One row of the directed table. When "known" is set, the readout is typed
  // in by hand. Otherwise the tracker model supplies it.
  typedef struct packed {
    logic [kwg_pkg::RAW_W-1:0]  sample;
    logic [kwg_pkg::TIME_W-1:0] stamp;
    logic                       known;
    readout_t                   readout;
  } knob_row_t;

  localparam readout_t UNCHECKED = '{8'd0, 8'd0, kwg_pkg::CMD_NONE, 1'b0};

  localparam int NUM_ROWS = 26;
  localparam knob_row_t DIRECTED_ROWS [0:NUM_ROWS-1] = '{
    // Three phases starting downward from the reset level of 150.
    '{10'd0,    32'd1000, 1'b1, '{8'd0,   8'd0,   kwg_pkg::CMD_NONE, 1'b0}},
    '{10'd1023, 32'd1010, 1'b1, '{8'd255, 8'd255, kwg_pkg::CMD_NONE, 1'b0}},
    '{10'd0,    32'd1020, 1'b1, '{8'd0,   8'd0,   kwg_pkg::CMD_NONE, 1'b0}},
    '{10'd0,    32'd1500, 1'b1, '{8'd0,   8'd0,   kwg_pkg::CMD_PREV, 1'b0}},
    // Five phases upward, then the pause runs out and setup is entered.
    '{10'd1023, 32'd2000, 1'b1, '{8'd255, 8'd255, kwg_pkg::CMD_NONE, 1'b0}},
    '{10'd0,    32'd2010, 1'b0, UNCHECKED},
    '{10'd1023, 32'd2020, 1'b0, UNCHECKED},
    '{10'd0,    32'd2030, 1'b0, UNCHECKED},
    '{10'd1023, 32'd2040, 1'b0, UNCHECKED},
    '{10'd1023, 32'd2500, 1'b1, '{8'd255, 8'd200, kwg_pkg::CMD_ENTER_SETUP, 1'b1}},
    // Inside setup a three-phase gesture gives no command.
    '{10'd0,    32'd3000, 1'b1, '{8'd0,   8'd200, kwg_pkg::CMD_NONE, 1'b1}},
    '{10'd1023, 32'd3010, 1'b0, UNCHECKED},
    '{10'd0,    32'd3020, 1'b0, UNCHECKED},
    '{10'd0,    32'd3500, 1'b1, '{8'd0,   8'd200, kwg_pkg::CMD_NONE, 1'b1}},
    // Five more phases leave setup again.
    '{10'd1023, 32'd4000, 1'b0, UNCHECKED},
    '{10'd0,    32'd4010, 1'b0, UNCHECKED},
    '{10'd1023, 32'd4020, 1'b0, UNCHECKED},
    '{10'd0,    32'd4030, 1'b0, UNCHECKED},
    '{10'd1023, 32'd4040, 1'b0, UNCHECKED},
    '{10'd1023, 32'd4500, 1'b1, '{8'd255, 8'd255, kwg_pkg::CMD_LEAVE_SETUP, 1'b0}},
    // A reversal only a few steps from the start level cancels the gesture.
    '{10'd1000, 32'd5000, 1'b0, UNCHECKED},
    '{10'd1023, 32'd5010, 1'b0, UNCHECKED},
    '{10'd1023, 32'd5500, 1'b0, UNCHECKED},
    // A gesture that starts just before the counter wraps. The first quiet
    // request stays inside the pause. The second one ends the gesture.
    '{10'd0,    32'hFFFF_FFF0, 1'b0, UNCHECKED},
    '{10'd0,    32'h0000_0100, 1'b0, UNCHECKED},
    '{10'd0,    32'h0000_0200, 1'b0, UNCHECKED}
  };

  // Register settings for the pinned phases. Entry zero equals the reset
  // values.
  localparam int NUM_FIXED = 6;
  localparam int NUM_PHASES = 8;
  localparam int SATURATE_PHASE = 5;
  localparam int PHASE_REQUESTS = 30;
  localparam kwg_pkg::cfg_t PHASE_SETTINGS [0:NUM_FIXED-1] = '{
    '{10'd0,    10'd1023, 1'b0, 8'd0,   8'd255, 8'd20,  16'd3000,  16'd400},
    '{10'd100,  10'd900,  1'b1, 8'd255, 8'd0,   8'd0,   16'd0,     16'd65535},
    '{10'd512,  10'd512,  1'b0, 8'd10,  8'd200, 8'd255, 16'd65535, 16'd0},
    '{10'd900,  10'd100,  1'b0, 8'd30,  8'd220, 8'd5,   16'd500,   16'd50},
    '{10'd0,    10'd1,    1'b1, 8'd0,   8'd255, 8'd10,  16'd200,   16'd30},
    '{10'd0,    10'd1023, 1'b0, 8'd0,   8'd255, 8'd0,   16'd65535, 16'd65535}
  };

  // The model's copy of the registers and of the tracker state.
  kwg_pkg::cfg_t                knob_cfg;
  logic [kwg_pkg::BRIGHT_W-1:0] level_now;
  logic                         gesture_on;
  logic [kwg_pkg::TIME_W-1:0]   gesture_t0;
  logic [kwg_pkg::TIME_W-1:0]   last_move_t;
  logic                         went_up_first;
  logic [kwg_pkg::BRIGHT_W-1:0] level_at_start;
  logic [kwg_pkg::BRIGHT_W-1:0] phase_n;
  logic                         setup_on;

  readout_t                   readouts_due[$];
  readout_t                   oldest;
  logic [kwg_pkg::TIME_W-1:0] clock_ms;
  int                         requests_sent;
  int                         fail_count;
  bit                         calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Safety net. A correct run takes a small fraction of this time.
  initial begin
    #6_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic reset_model();
    knob_cfg = PHASE_SETTINGS[0];
    level_now = kwg_pkg::LEVEL_RESET;
    gesture_on = 1'b0;
    gesture_t0 = '0;
    last_move_t = '0;
    went_up_first = 1'b1;
    level_at_start = '0;
    phase_n = '0;
    setup_on = 1'b0;
  endtask

  // Clamp, optional mirror and linear map with truncation toward zero. Only
  // the low byte of the mapped value is kept.
  function automatic logic [kwg_pkg::BRIGHT_W-1:0] knob_to_brightness(
      input logic [kwg_pkg::RAW_W-1:0] raw);
    int lo, hi, v, r;
    lo = int'(knob_cfg.pot_min);
    hi = int'(knob_cfg.pot_max);
    v = int'(raw);
    if (v < lo) v = lo;
    else if (v > hi) v = hi;
    if (knob_cfg.invert) v = hi - v + lo;
    if (hi == lo) begin
      r = int'(knob_cfg.bright_min);
    end else begin
      r = (v - lo) * (int'(knob_cfg.bright_max) - int'(knob_cfg.bright_min)) / (hi - lo)
          + int'(knob_cfg.bright_min);
    end
    return r[kwg_pkg::BRIGHT_W-1:0];
  endfunction

  // Advance the tracker by one request and work out the readout it yields.
  task automatic predict_readout(input logic [kwg_pkg::RAW_W-1:0] raw,
                                 input logic [kwg_pkg::TIME_W-1:0] stamp,
                                 output readout_t ro);
    logic [kwg_pkg::BRIGHT_W-1:0] b;
    logic [kwg_pkg::TIME_W-1:0]   since_start, since_move;
    kwg_pkg::cmd_code_t           cmd;
    logic                         up;
    int                           swing;
    b = knob_to_brightness(raw);
    cmd = kwg_pkg::CMD_NONE;
    since_start = stamp - gesture_t0;
    since_move = stamp - last_move_t;
    if (b != level_now) begin
      if (!gesture_on) begin
        // When the tracker is idle, a change starts a gesture and skips the
        // expiry check.
        gesture_on = 1'b1;
        gesture_t0 = stamp;
        last_move_t = stamp;
        went_up_first = (b > level_now);
        level_at_start = level_now;
        phase_n = 8'd1;
      end else begin
        up = went_up_first;
        last_move_t = stamp;
        if (!phase_n[0]) up = !up;
        if ((up && level_now > b) || (!up && level_now < b)) begin
          // A reversal. In an odd phase the swing from the start level has
          // to reach min_swing, or else the gesture is dropped.
          swing = int'(level_now) - int'(level_at_start);
          if (!up) swing = -swing;
          if (phase_n[0] && swing < int'(knob_cfg.min_swing)) gesture_on = 1'b0;
          else if (phase_n != kwg_pkg::PHASE_MAX) phase_n = phase_n + 8'd1;
        end
      end
      level_now = b;
    end else if (gesture_on &&
                 (since_start > kwg_pkg::TIME_W'(knob_cfg.window_ms) ||
                  since_move > kwg_pkg::TIME_W'(knob_cfg.pause_ms))) begin
      if (phase_n == kwg_pkg::PHASE_NEXT && !setup_on) begin
        cmd = went_up_first ? kwg_pkg::CMD_NEXT : kwg_pkg::CMD_PREV;
      end else if (phase_n == kwg_pkg::PHASE_SETUP) begin
        cmd = setup_on ? kwg_pkg::CMD_LEAVE_SETUP : kwg_pkg::CMD_ENTER_SETUP;
        setup_on = !setup_on;
      end
      gesture_on = 1'b0;
    end
    ro.brightness = b;
    ro.shown = setup_on ? kwg_pkg::SETUP_BRIGHT : b;
    ro.command = cmd;
    ro.setup = setup_on;
  endtask

  // Mostly back to back or short gaps, with the odd long one. No gaps at
  // all while a calm phase runs.
  function automatic int idle_cycles();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one request and wait for the handshake. The readout is queued at
  // the edge that accepts the request. If valid is to stay high for the
  // next request, it is not touched in between, so no step sees two writes
  // to it.
  task automatic send_request(input logic [kwg_pkg::RAW_W-1:0] raw,
                              input logic [kwg_pkg::TIME_W-1:0] stamp,
                              input logic known, input readout_t typed);
    int gap;
    readout_t predicted;
    gap = idle_cycles();
    if (gap > 0) begin
      knob_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    knob_if.valid <= 1'b1;
    knob_if.sample <= raw;
    knob_if.now_ms <= stamp;
    @(posedge clk);
    while (!knob_if.ready) @(posedge clk);
    predict_readout(raw, stamp, predicted);
    if (known) predicted = typed;
    readouts_due = {readouts_due, predicted};
    requests_sent++;
  endtask

  task automatic send_knob(input int raw);
    send_request(kwg_pkg::RAW_W'(raw), clock_ms, 1'b0, UNCHECKED);
  endtask

  task automatic put_reg(input kwg_pkg::cfg_idx_t idx,
                         input logic [kwg_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // All eight registers are written back to back. The block is idle here.
  task automatic apply_settings(input kwg_pkg::cfg_t s);
    put_reg(kwg_pkg::CFG_POT_MIN, kwg_pkg::CFG_DATA_W'(s.pot_min));
    put_reg(kwg_pkg::CFG_POT_MAX, kwg_pkg::CFG_DATA_W'(s.pot_max));
    put_reg(kwg_pkg::CFG_INVERT, kwg_pkg::CFG_DATA_W'(s.invert));
    put_reg(kwg_pkg::CFG_BRIGHT_MIN, kwg_pkg::CFG_DATA_W'(s.bright_min));
    put_reg(kwg_pkg::CFG_BRIGHT_MAX, kwg_pkg::CFG_DATA_W'(s.bright_max));
    put_reg(kwg_pkg::CFG_MIN_SWING, kwg_pkg::CFG_DATA_W'(s.min_swing));
    put_reg(kwg_pkg::CFG_WINDOW, s.window_ms);
    put_reg(kwg_pkg::CFG_PAUSE, s.pause_ms);
    cfg_we <= 1'b0;
    knob_cfg = s;
  endtask

  function automatic kwg_pkg::cfg_t random_settings();
    kwg_pkg::cfg_t s;
    s.pot_min = kwg_pkg::RAW_W'($urandom_range(0, 500));
    s.pot_max = kwg_pkg::RAW_W'($urandom_range(400, 1023));
    s.invert = 1'($urandom_range(0, 1));
    s.bright_min = kwg_pkg::BRIGHT_W'($urandom_range(0, 255));
    s.bright_max = kwg_pkg::BRIGHT_W'($urandom_range(0, 255));
    s.min_swing = kwg_pkg::BRIGHT_W'($urandom_range(0, 60));
    s.window_ms = kwg_pkg::MS_W'($urandom_range(0, 4000));
    s.pause_ms = kwg_pkg::MS_W'($urandom_range(0, 500));
    return s;
  endfunction

  // Three and five phases are the ones that do something, so they come up
  // most often.
  function automatic int gesture_length();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 3;
    if (r < 7) return 5;
    return $urandom_range(1, 8);
  endfunction

  // Swing the knob back and forth "turns" times between a low and a high
  // position, then leave it still until the pause runs out. A timid wiggle
  // uses a small amplitude, which lets the swing check cancel it.
  task automatic wiggle(input int turns, input bit timid, input int step_max);
    int lo_edge, hi_edge, lo_s, hi_s, target, prev;
    bit at_high;
    lo_edge = (knob_cfg.pot_min < knob_cfg.pot_max) ? knob_cfg.pot_min : knob_cfg.pot_max;
    hi_edge = (knob_cfg.pot_min < knob_cfg.pot_max) ? knob_cfg.pot_max : knob_cfg.pot_min;
    lo_s = $urandom_range(0, 1) ? $urandom_range(0, lo_edge) : lo_edge + $urandom_range(0, 15);
    if (timid) hi_s = lo_s + $urandom_range(1, 30);
    else if ($urandom_range(0, 1)) hi_s = $urandom_range(hi_edge, 1023);
    else hi_s = hi_edge - $urandom_range(0, 15);
    if (lo_s > 1023) lo_s = 1023;
    if (hi_s > 1023) hi_s = 1023;
    if (hi_s < 0) hi_s = 0;
    at_high = 1'($urandom_range(0, 1));
    prev = at_high ? lo_s : hi_s;
    for (int k = 0; k < turns; k++) begin
      target = at_high ? hi_s : lo_s;
      // Sometimes the knob passes a middle position on its way. The move
      // stays monotonic, so it is not a reversal.
      if (k > 0 && $urandom_range(0, 3) == 0) begin
        clock_ms += $urandom_range(1, step_max);
        send_knob((target + prev) / 2);
      end
      clock_ms += $urandom_range(1, step_max);
      send_knob(target);
      prev = target;
      at_high = !at_high;
    end
    // A quiet request exactly at the pause limit must not end the gesture
    // by the pause alone. One step later it must.
    if ($urandom_range(0, 3) == 0) begin
      clock_ms += knob_cfg.pause_ms;
      send_knob(prev);
    end
    clock_ms += knob_cfg.pause_ms + 1 + $urandom_range(0, 40);
    send_knob(prev);
  endtask

  task automatic wait_for_readouts();
    do @(posedge clk); while (readouts_due.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [kwg_pkg::BRIGHT_W-1:0] want,
                             input logic [kwg_pkg::BRIGHT_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // The result side takes readouts with random stalls. Ready goes high again
  // between any two stalls.
  initial begin : readout_sink
    int stall;
    readout_if.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      readout_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      stall = idle_cycles();
      if (stall > 0) begin
        readout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Each accepted readout is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && readout_if.valid && readout_if.ready) begin
      if (readouts_due.size() == 0) begin
        fail_count++;
        $display("%0t: readout with no request outstanding", $time);
      end else begin
        oldest = readouts_due.pop_front();
        check_field("brightness", oldest.brightness, readout_if.brightness);
        check_field("shown_brightness", oldest.shown, readout_if.shown_brightness);
        check_field("command", kwg_pkg::BRIGHT_W'(oldest.command),
                    kwg_pkg::BRIGHT_W'(readout_if.command));
        check_field("setup_active", kwg_pkg::BRIGHT_W'(oldest.setup),
                    kwg_pkg::BRIGHT_W'(readout_if.setup_active));
      end
    end
  end

  initial begin : stimulus
    int goal, pick;
    kwg_pkg::cfg_t s;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = kwg_pkg::CFG_POT_MIN;
    cfg_wdata = '0;
    knob_if.valid = 1'b0;
    knob_if.sample = '0;
    knob_if.now_ms = '0;
    fail_count = 0;
    requests_sent = 0;
    calm = 1'b0;
    clock_ms = 32'h0000_1000;
    reset_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The directed table runs under the reset settings.
    for (int i = 0; i < NUM_ROWS; i++)
      send_request(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].stamp,
                   DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].readout);

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Registers change only once every readout of the last phase is in.
      knob_if.valid <= 1'b0;
      wait_for_readouts();
      s = (p < NUM_FIXED) ? PHASE_SETTINGS[p] : random_settings();
      apply_settings(s);
      calm = (p % 3 == 2);
      if (p == 6) clock_ms = 32'hFFFF_F000;
      else if (p > 0 && $urandom_range(0, 1)) clock_ms = $urandom();

      goal = requests_sent + PHASE_REQUESTS;

      // Run the phase count up past its ceiling while the window and the
      // pause are at their largest. This long wiggle fills the whole phase.
      if (p == SATURATE_PHASE) wiggle(260, 1'b0, 40);

      while (requests_sent < goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          wiggle(gesture_length(), 1'b0, 120);
        end else if (pick == 6) begin
          wiggle(gesture_length(), 1'b1, 120);
        end else if (pick == 7) begin
          // A slow wiggle, long enough that the window can run out first.
          wiggle(gesture_length(), 1'b0, int'(knob_cfg.window_ms) / 2 + 1);
        end else begin
          repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(0, 7) == 0) clock_ms = $urandom();
            else clock_ms += $urandom_range(0, 800);
            send_knob($urandom_range(0, 1023));
          end
        end
      end
    end

    knob_if.valid <= 1'b0;
    wait_for_readouts();
    repeat (30) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/kwg_pkg.sv
rtl/kwg_in_if.sv
rtl/kwg_out_if.sv
rtl/kwg_cfg_regs.sv
rtl/kwg_ctrl.sv
rtl/kwg_datapath.sv
rtl/knob_wiggle_gesture_detector.sv
test/knob_wiggle_gesture_detector_test.sv
